@@ rtl/amdec_pkg.sv @@
package amdec_pkg;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CFG_ALPHA_FORMAT  = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_LAYER_CHANNEL = 1'd1;
  localparam int unsigned CfgDataW = 2;

  // alpha_format bit meanings
  localparam int unsigned FMT_RLE_BIT = 1;
  localparam int unsigned FMT_RAW_BIT = 0;

  localparam logic [7:0] HDR_FILL_MASK  = 8'h80;
  localparam logic [7:0] HDR_COUNT_MASK = 8'h7F;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_FILL   = 2'd1,
    PH_COPY   = 2'd2
  } phase_e;

  typedef struct packed {
    logic [7:0] src_byte;
    logic       map_start;
  } in_beat_t;

  typedef struct packed {
    logic [7:0]  alpha_value;
    logic [13:0] blend_address;
    logic [6:0]  run_length;
    logic        last_of_item;
    logic        map_done;
  } out_beat_t;

  // results caused by one accepted byte, in order
  typedef struct packed {
    logic [1:0] count;
    out_beat_t  first;
    out_beat_t  second;
  } dec_res_t;

endpackage

@@ rtl/alpha_map_byte_decoder_unit.sv @@
// Alpha map byte decoder: turns an encoded byte stream into alpha results.
// Input channel: one encoded byte per beat, with map_start on the first byte
// of a map. Output channel: one result per beat (alpha, blend address, run
// length, last-of-byte and map-done flags). Fill runs leave as one beat.
// Configuration: write alpha_format and layer_channel through the write port
// while the block is idle; writes take effect at once and keep decode state.
// A byte's results are registered in the result buffer before they are offered.
// Throughput: raw 8-bit and run-length bytes are taken one per cycle while
// the receiver does not stall; packed 4-bit bytes make two results each and
// fill the buffer, so the next byte waits until the output port drains one.
// A three-entry result buffer sits on the output; in_stall_o is high while it
// holds two or more beats, so a further byte is still taken while one result
// waits on a stalled receiver. A stalled output beat holds until taken.
// Reset clears the decode state, the buffer's beat count and both registers to zero.
module alpha_map_byte_decoder_unit #(
  parameter int unsigned MAP_SIZE  = 4096,
  parameter int unsigned ROW_WIDTH = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  amdec_pkg::in_beat_t                 in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output amdec_pkg::out_beat_t                out_data_o,
  input  logic                                cfg_we_i,
  input  logic [amdec_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [amdec_pkg::CfgDataW-1:0]      cfg_data_i
);
  import amdec_pkg::*;

  logic       in_accept;
  logic       buf_full;
  logic [1:0] alpha_format_q;
  logic [1:0] layer_channel_q;
  dec_res_t   dec_res;

  assign in_stall_o = buf_full;
  assign in_accept  = in_valid_i && !buf_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_format_q  <= '0;
      layer_channel_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_ALPHA_FORMAT:  alpha_format_q  <= cfg_data_i;
        CFG_LAYER_CHANNEL: layer_channel_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  amdec_decoder #(
    .MAP_SIZE  (MAP_SIZE),
    .ROW_WIDTH (ROW_WIDTH)
  ) u_decoder (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (in_accept),
    .in_data_i       (in_data_i),
    .alpha_format_i  (alpha_format_q),
    .layer_channel_i (layer_channel_q),
    .res_o           (dec_res)
  );

  amdec_result_buf u_result_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_i       (dec_res),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

@@ rtl/amdec_decoder.sv @@
module amdec_decoder #(
  parameter int unsigned MAP_SIZE  = 4096,
  parameter int unsigned ROW_WIDTH = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  amdec_pkg::in_beat_t in_data_i,
  input  logic [1:0]          alpha_format_i,
  input  logic [1:0]          layer_channel_i,
  output amdec_pkg::dec_res_t res_o
);
  import amdec_pkg::*;

  localparam int unsigned PosW    = $clog2(MAP_SIZE + 1);
  localparam int unsigned HalfRow = ROW_WIDTH / 2;
  localparam int unsigned RbcW    = (HalfRow > 1) ? $clog2(HalfRow) : 1;
  localparam logic [PosW-1:0] MapSz   = PosW'(MAP_SIZE);
  localparam logic [RbcW-1:0] RowLast = RbcW'(HalfRow - 1);

  phase_e          phase_q, phase_d, phase_e_s;
  logic [6:0]      rr_q, rr_d, rr_e;
  logic [PosW-1:0] pos_q, pos_d, pos_e;
  logic [RbcW-1:0] rbc_q, rbc_d, rbc_e;
  logic            mc_q, mc_d, mc_e;

  logic [PosW-1:0] left;
  logic [PosW-1:0] pos_n1;
  logic [PosW-1:0] pos_n2;
  logic [PosW-1:0] pos_fill;
  logic [6:0]      run;
  logic [3:0]      lo_nib, hi_nib;
  logic            row_end;
  logic [7:0]      src;

  function automatic out_beat_t mk_beat(input logic [7:0] alpha, input logic [PosW-1:0] pos,
                                        input logic [6:0] len, input logic last,
                                        input logic done, input logic [1:0] lane);
    out_beat_t b;
    logic [PosW+1:0] addr;
    addr            = {pos, lane};
    b.alpha_value   = alpha;
    b.blend_address = 14'(addr);
    b.run_length    = len;
    b.last_of_item  = last;
    b.map_done      = done;
    return b;
  endfunction

  always_comb begin
    src = in_data_i.src_byte;
    // a new map starts from cleared state
    if (in_data_i.map_start) begin
      phase_e_s = PH_HEADER;
      rr_e      = '0;
      pos_e     = '0;
      rbc_e     = '0;
      mc_e      = 1'b0;
    end else begin
      phase_e_s = phase_q;
      rr_e      = rr_q;
      pos_e     = pos_q;
      rbc_e     = rbc_q;
      mc_e      = mc_q;
    end

    left     = MapSz - pos_e;
    run      = (PosW'(rr_e) > left) ? left[6:0] : rr_e;
    pos_fill = pos_e + PosW'(run);
    pos_n1   = pos_e + PosW'(1);
    pos_n2   = pos_e + PosW'(2);
    lo_nib   = src[3:0];
    row_end  = (rbc_e == RowLast);
    hi_nib   = row_end ? src[3:0] : src[7:4];

    phase_d = phase_e_s;
    rr_d    = rr_e;
    pos_d   = pos_e;
    rbc_d   = rbc_e;
    mc_d    = mc_e;

    res_o.count  = 2'd0;
    res_o.first  = mk_beat(src, pos_e, 7'd1, 1'b1, 1'b0, layer_channel_i);
    res_o.second = mk_beat(src, pos_n1, 7'd1, 1'b1, 1'b0, layer_channel_i);

    priority if (mc_e || pos_e >= MapSz) begin
      // drop bytes after the map is complete
      mc_d = 1'b1;
    end else if (alpha_format_i[FMT_RLE_BIT]) begin
      unique case (phase_e_s)
        PH_FILL: begin
          pos_d       = pos_fill;
          mc_d        = pos_fill >= MapSz;
          phase_d     = PH_HEADER;
          rr_d        = '0;
          res_o.count = 2'd1;
          res_o.first = mk_beat(src, pos_e, run, 1'b1, pos_fill >= MapSz, layer_channel_i);
        end
        PH_COPY: begin
          pos_d       = pos_n1;
          mc_d        = pos_n1 >= MapSz;
          rr_d        = rr_e - 7'd1;
          if (rr_e == 7'd1) begin
            phase_d = PH_HEADER;
          end
          res_o.count = 2'd1;
          res_o.first = mk_beat(src, pos_e, 7'd1, 1'b1, pos_n1 >= MapSz, layer_channel_i);
        end
        default: begin
          rr_d = src[6:0] & HDR_COUNT_MASK[6:0];
          if ((src & HDR_COUNT_MASK) == 8'h00) begin
            phase_d = PH_HEADER;
          end else if ((src & HDR_FILL_MASK) != 8'h00) begin
            phase_d = PH_FILL;
          end else begin
            phase_d = PH_COPY;
          end
        end
      endcase
    end else if (alpha_format_i[FMT_RAW_BIT]) begin
      pos_d       = pos_n1;
      mc_d        = pos_n1 >= MapSz;
      res_o.count = 2'd1;
      res_o.first = mk_beat(src, pos_e, 7'd1, 1'b1, pos_n1 >= MapSz, layer_channel_i);
    end else begin
      // packed nibbles: value times 17 is the nibble repeated
      rbc_d = row_end ? '0 : rbc_e + RbcW'(1);
      if (pos_n1 >= MapSz) begin
        pos_d       = pos_n1;
        mc_d        = 1'b1;
        res_o.count = 2'd1;
        res_o.first = mk_beat({lo_nib, lo_nib}, pos_e, 7'd1, 1'b1, 1'b1, layer_channel_i);
      end else begin
        pos_d        = pos_n2;
        mc_d         = pos_n2 >= MapSz;
        res_o.count  = 2'd2;
        res_o.first  = mk_beat({lo_nib, lo_nib}, pos_e, 7'd1, 1'b0, 1'b0, layer_channel_i);
        res_o.second = mk_beat({hi_nib, hi_nib}, pos_n1, 7'd1, 1'b1, pos_n2 >= MapSz,
                               layer_channel_i);
      end
    end

    if (!accept_i) begin
      res_o.count = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      rr_q    <= '0;
      pos_q   <= '0;
      rbc_q   <= '0;
      mc_q    <= 1'b0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      rr_q    <= rr_d;
      pos_q   <= pos_d;
      rbc_q   <= rbc_d;
      mc_q    <= mc_d;
    end
  end

endmodule

@@ rtl/amdec_result_buf.sv @@
module amdec_result_buf (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  amdec_pkg::dec_res_t  res_i,
  output logic                 full_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output amdec_pkg::out_beat_t out_data_o
);
  import amdec_pkg::*;

  localparam int unsigned Depth = 3;

  out_beat_t  slot_q [Depth];
  out_beat_t  slot_d [Depth];
  logic [1:0] cnt_q, cnt_d;
  logic [1:0] base;
  logic       pop;

  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = slot_q[0];
  assign pop         = out_valid_o && !out_stall_i;
  // room for two more beats only while at most one is held
  assign full_o      = (cnt_q >= 2'd2);

  always_comb begin
    slot_d = slot_q;
    if (pop) begin
      slot_d[0] = slot_q[1];
      slot_d[1] = slot_q[2];
    end
    base = cnt_q - {1'b0, pop};
    if (res_i.count != 2'd0) begin
      slot_d[base] = res_i.first;
    end
    if (res_i.count == 2'd2) begin
      slot_d[base + 2'd1] = res_i.second;
    end
    cnt_d = base + res_i.count;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

endmodule

@@ bench/tb_alpha_map_byte_decoder_unit.sv @@
module tb_alpha_map_byte_decoder_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import amdec_pkg::*;

  localparam int unsigned MapSize    = 4096;
  localparam int unsigned RowWidth   = 64;
  localparam int unsigned ItemTarget = 1200;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned CycleLimit = 400000;

  localparam logic [1:0] FMT_PACKED  = 2'd0;
  localparam logic [1:0] FMT_RAW     = 2'd1;
  localparam logic [1:0] FMT_RLE     = 2'd2;
  localparam logic [1:0] FMT_RLE_ALT = 2'd3;

  class alpha_decode_tracker;
    logic [1:0]  fmt;
    logic [1:0]  lane;
    phase_e      phase;
    logic [6:0]  run_left;
    int unsigned pos;
    int unsigned row_bytes;
    bit          complete;
    out_beat_t   expected_alphas[$];
    int unsigned mismatches;

    function void clear_map();
      phase     = PH_HEADER;
      run_left  = '0;
      pos       = 0;
      row_bytes = 0;
      complete  = 1'b0;
    endfunction

    function void reset_all();
      clear_map();
      fmt        = FMT_PACKED;
      lane       = 2'd0;
      mismatches = 0;
      expected_alphas.delete();
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
      if (idx == CFG_ALPHA_FORMAT) begin
        fmt = val;
      end else if (idx == CFG_LAYER_CHANNEL) begin
        lane = val;
      end
    endfunction

    // pos must already be advanced past this result
    function void expect_alpha(logic [7:0] value, int unsigned at, int unsigned run, bit last);
      out_beat_t e;
      e.alpha_value   = value;
      e.blend_address = 14'(at * 4 + lane);
      e.run_length    = 7'(run);
      e.last_of_item  = last;
      e.map_done      = (pos >= MapSize);
      expected_alphas.push_back(e);
    endfunction

    function void note_byte(in_beat_t b);
      int unsigned left;
      int unsigned at;
      int unsigned run;
      logic [3:0]  lo;
      logic [3:0]  hi;
      bit          row_end;
      if (b.map_start) clear_map();
      if (complete || pos >= MapSize) begin
        complete = 1'b1;
        return;
      end
      left = MapSize - pos;
      at   = pos;
      if (fmt[FMT_RLE_BIT]) begin
        case (phase)
          PH_FILL: begin
            run = 32'(run_left);
            if (run > left) run = left;
            pos += run;
            expect_alpha(b.src_byte, at, run, 1'b1);
            phase    = PH_HEADER;
            run_left = '0;
          end
          PH_COPY: begin
            pos += 1;
            expect_alpha(b.src_byte, at, 1, 1'b1);
            run_left = run_left - 7'd1;
            if (run_left == 7'd0) phase = PH_HEADER;
          end
          default: begin
            run_left = 7'(b.src_byte & HDR_COUNT_MASK);
            if (run_left == 7'd0) begin
              phase = PH_HEADER;
            end else if ((b.src_byte & HDR_FILL_MASK) != 8'd0) begin
              phase = PH_FILL;
            end else begin
              phase = PH_COPY;
            end
          end
        endcase
      end else if (fmt[FMT_RAW_BIT]) begin
        pos += 1;
        expect_alpha(b.src_byte, at, 1, 1'b1);
      end else begin
        lo      = b.src_byte[3:0];
        hi      = b.src_byte[7:4];
        row_end = (row_bytes + 1) >= RowWidth / 2;
        // last byte of a row repeats its low nibble
        if (row_end) hi = lo;
        row_bytes = row_end ? 0 : row_bytes + 1;
        pos += 1;
        if (pos >= MapSize) begin
          expect_alpha(8'(lo * 17), at, 1, 1'b1);
        end else begin
          expect_alpha(8'(lo * 17), at, 1, 1'b0);
          pos += 1;
          expect_alpha(8'(hi * 17), at + 1, 1, 1'b1);
        end
      end
      complete = (pos >= MapSize);
    endfunction

    function void check_alpha(out_beat_t got);
      out_beat_t e;
      if (expected_alphas.size() == 0) begin
        $error("unexpected result beat: alpha %0d address %0d", got.alpha_value,
               got.blend_address);
        mismatches++;
        return;
      end
      e = expected_alphas.pop_front();
      if (got.alpha_value !== e.alpha_value) begin
        $error("alpha_value: expected %0d, actual %0d", e.alpha_value, got.alpha_value);
        mismatches++;
      end
      if (got.blend_address !== e.blend_address) begin
        $error("blend_address: expected %0d, actual %0d", e.blend_address,
               got.blend_address);
        mismatches++;
      end
      if (got.run_length !== e.run_length) begin
        $error("run_length: expected %0d, actual %0d", e.run_length, got.run_length);
        mismatches++;
      end
      if (got.last_of_item !== e.last_of_item) begin
        $error("last_of_item: expected %0d, actual %0d", e.last_of_item, got.last_of_item);
        mismatches++;
      end
      if (got.map_done !== e.map_done) begin
        $error("map_done: expected %0d, actual %0d", e.map_done, got.map_done);
        mismatches++;
      end
    endfunction

    function int unsigned outstanding();
      return expected_alphas.size();
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  in_beat_t            in_data;
  logic                out_valid;
  logic                out_stall;
  out_beat_t           out_data;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  alpha_decode_tracker tracker;
  in_beat_t            stim_q[$];
  int unsigned         items_sent;
  int unsigned         cycles;
  bit                  calm;
  bit                  hold_req;

  alpha_map_byte_decoder_unit #(
    .MAP_SIZE (MapSize),
    .ROW_WIDTH(RowWidth)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAILED: results differ");
    $finish;
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HoldCycles;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 6);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) tracker.check_alpha(out_data);
  end

  task automatic add_beat(input logic [7:0] value, input bit start);
    in_beat_t b;
    b.src_byte  = value;
    b.map_start = start;
    stim_q.push_back(b);
  endtask

  task automatic send_stim();
    in_beat_t b;
    while (stim_q.size() != 0) begin
      b = stim_q.pop_front();
      @(negedge clk);
      while (!calm && $urandom_range(99) < 6) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
      in_valid <= 1'b1;
      in_data  <= b;
      @(posedge clk);
      while (in_stall) @(posedge clk);
      tracker.note_byte(b);
      items_sent++;
    end
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // wait for every expected beat, then let the pipeline drain
  task automatic settle();
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    tracker.write_reg(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_cfg(input logic [1:0] fmt, input logic [1:0] lane);
    settle();
    write_reg(CFG_ALPHA_FORMAT, fmt);
    write_reg(CFG_LAYER_CHANNEL, lane);
  endtask

  task automatic gen_loose(input int unsigned n, input bit first_start, input int unsigned odds);
    for (int unsigned i = 0; i < n; i++) begin
      add_beat(8'($urandom()), (i == 0) ? first_start : ($urandom_range(odds - 1) == 0));
    end
  endtask

  // well-formed run-length map with some noise and cut-short copies
  task automatic gen_rle_map(input int unsigned n);
    bit          first;
    bit          fill;
    int unsigned count;
    int unsigned body;
    first = 1'b1;
    while (stim_q.size() < n) begin
      if ($urandom_range(19) == 0) begin
        add_beat(8'($urandom()), first);
        first = 1'b0;
        continue;
      end
      fill = 1'($urandom_range(1));
      case ($urandom_range(15))
        0:       count = 0;
        1, 2:    count = fill ? $urandom_range(9, 127) : $urandom_range(9, 24);
        default: count = $urandom_range(1, 8);
      endcase
      add_beat({fill, 7'(count)}, first);
      first = 1'b0;
      if (count == 0) continue;
      if (fill) begin
        add_beat(8'($urandom()), 1'b0);
      end else begin
        body = ($urandom_range(15) == 0) ? $urandom_range(count) : count;
        repeat (body) add_beat(8'($urandom()), 1'b0);
      end
    end
  endtask

  // fill the map up to a few positions short of its end
  task automatic gen_rush(input int unsigned short_by);
    int unsigned target;
    int unsigned at;
    int unsigned c;
    bit          first;
    target = MapSize - short_by;
    at     = 0;
    first  = 1'b1;
    while (at < target) begin
      c = target - at;
      if (c > 127) c = 127;
      if ($urandom_range(7) == 0) begin
        c = $urandom_range(1, (c < 4) ? c : 4);
        add_beat({1'b0, 7'(c)}, first);
        repeat (c) add_beat(8'($urandom()), 1'b0);
      end else begin
        add_beat({1'b1, 7'(c)}, first);
        add_beat(8'($urandom()), 1'b0);
      end
      first = 1'b0;
      at += c;
    end
  endtask

  initial begin
    int unsigned phase_no;
    int unsigned kind;
    tracker    = new();
    tracker.reset_all();
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_we     = 1'b0;
    cfg_index  = CFG_ALPHA_FORMAT;
    cfg_data   = '0;
    calm       = 1'b0;
    hold_req   = 1'b0;
    items_sent = 0;
    cycles     = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // packed nibbles at the extremes, top lane
    apply_cfg(FMT_PACKED, 2'd3);
    add_beat(8'h00, 1'b1);
    add_beat(8'hFF, 1'b0);
    add_beat(8'h0F, 1'b0);
    add_beat(8'hF0, 1'b0);
    add_beat(8'hA5, 1'b0);
    send_stim();

    // raw bytes carry on the same map, then restart it
    apply_cfg(FMT_RAW, 2'd0);
    add_beat(8'h00, 1'b0);
    add_beat(8'hFF, 1'b0);
    add_beat(8'h80, 1'b1);
    send_stim();

    // zero-count headers, fill, copy and a full-length fill
    apply_cfg(FMT_RLE, 2'd2);
    add_beat(8'h00, 1'b1);
    add_beat(8'h80, 1'b0);
    add_beat(8'h83, 1'b0);
    add_beat(8'hFF, 1'b0);
    add_beat(8'h02, 1'b0);
    add_beat(8'h00, 1'b0);
    add_beat(8'h7F, 1'b0);
    add_beat(8'hFF, 1'b0);
    add_beat(8'h01, 1'b0);
    send_stim();

    // format three decodes as run-length
    apply_cfg(FMT_RLE_ALT, 2'd1);
    add_beat(8'h81, 1'b0);
    add_beat(8'h55, 1'b0);
    add_beat(8'h01, 1'b0);
    add_beat(8'hAA, 1'b0);
    send_stim();

    phase_no = 0;
    while (items_sent < ItemTarget) begin
      kind = (phase_no == 0) ? 1 : (phase_no == 2) ? 3 : $urandom_range(4);
      calm = (phase_no >= 5 && phase_no < 8);
      case (kind)
        0: begin
          apply_cfg($urandom_range(1) ? FMT_RLE : FMT_RLE_ALT, 2'($urandom_range(3)));
          gen_rle_map($urandom_range(20, 80));
          send_stim();
        end
        1: begin
          apply_cfg($urandom_range(1) ? FMT_RLE : FMT_RLE_ALT, 2'($urandom_range(3)));
          gen_rush($urandom_range(0, 8));
          send_stim();
          // cross the map end in any format, then run into dropped bytes
          apply_cfg(2'($urandom_range(3)), 2'($urandom_range(3)));
          gen_loose($urandom_range(4, 20), 1'b0, 64);
          send_stim();
        end
        2: begin
          apply_cfg(FMT_PACKED, 2'($urandom_range(3)));
          gen_loose($urandom_range(20, 80), 1'($urandom_range(1)), 40);
          send_stim();
        end
        3: begin
          apply_cfg(FMT_RAW, 2'($urandom_range(3)));
          if (phase_no == 2) hold_req = 1'b1;
          gen_loose((phase_no == 2) ? 80 : $urandom_range(20, 80), 1'($urandom_range(1)), 40);
          send_stim();
        end
        default: begin
          apply_cfg(2'($urandom_range(3)), 2'($urandom_range(3)));
          gen_loose($urandom_range(10, 40), 1'b0, 8);
          send_stim();
        end
      endcase
      phase_no++;
    end
    calm = 1'b0;

    settle();
    repeat (16) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/amdec_pkg.sv
rtl/amdec_decoder.sv
rtl/amdec_result_buf.sv
rtl/alpha_map_byte_decoder_unit.sv
bench/tb_alpha_map_byte_decoder_unit.sv
